FILE: design/etri_pkg.sv
// Shared types for the enclosing triangle from hull block: FSM states and control records.
package etri_pkg;

  // Controller states
  typedef enum logic [5:0] {
    S_LOAD, S_START, S_PR_RD, S_PR_WR,
    S_SO_RD, S_SO_LD, S_SO_CMP, S_SO_B, S_SO_X, S_SO_DEC,
    S_SC_INIT, S_SC_INIT2, S_SC_RD, S_SC_LD, S_SC_CHK, S_SC_DEC, S_SC_SEC,
    S_CL_CHK, S_CL_DEC, S_CL_SEC,
    S_SW_INIT, S_V1, S_V1A, S_V1C, S_K, S_KB, S_AC, S_AC_DEC, S_AD_LD, S_AD, S_AD_DEC,
    S_BEST, S_OUT_RD0, S_OUT_RD1, S_OUT_RD2, S_OUT_RD3, S_EMIT, S_DEGEN,
    S_XW1, S_XW2
  } etri_state_t;

  // Point store write source
  typedef enum logic [1:0] {STW_IN, STW_REL, STW_B, STW_T} stw_sel_t;

  // Hull stack write source
  typedef enum logic [1:0] {SKW_ZERO, SKW_STORE, SKW_B} skw_sel_t;

  // Register that captures read data
  typedef enum logic [3:0] {
    CAP_NONE, CAP_P0, CAP_T, CAP_B, CAP_TOP, CAP_SEC, CAP_PA, CAP_PB, CAP_PC, CAP_PD
  } cap_sel_t;

  // Cross product operand select
  typedef enum logic [2:0] {X_NONE, X_SORT, X_TURN, X_CLOSE, X_AREA_C, X_AREA_D} xsel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       st_we;
    stw_sel_t   st_wsel;
    logic       rel_zero;
    logic       rel_lo;
    logic       sk_we;
    skw_sel_t   sk_wsel;
    cap_sel_t   st_cap;
    cap_sel_t   sk_cap;
    xsel_t      xsel;
    logic       piv_ld;
    logic       sec_clr;
    logic       push;
    logic       pop;
    logic       pc_from_pd;
    logic       area_ld;
    logic       best_clr;
    logic       best_ld;
    logic       out_ld;
    logic [1:0] out_num;
    logic       out_last;
    logic       out_degen;
    logic       out_ovf;
  } etri_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_lt_min;
    logic cross_pos;
    logic cross_zero;
    logic man_less;
    logic c_lt_d;
    logic best_upd;
    logic out_free;
  } etri_sts_t;

  localparam etri_cmd_t CMD_IDLE = '{
    st_we: 1'b0, st_wsel: STW_IN, rel_zero: 1'b0, rel_lo: 1'b0,
    sk_we: 1'b0, sk_wsel: SKW_ZERO, st_cap: CAP_NONE, sk_cap: CAP_NONE,
    xsel: X_NONE, piv_ld: 1'b0, sec_clr: 1'b0, push: 1'b0, pop: 1'b0,
    pc_from_pd: 1'b0, area_ld: 1'b0, best_clr: 1'b0, best_ld: 1'b0,
    out_ld: 1'b0, out_num: 2'd0, out_last: 1'b0, out_degen: 1'b0, out_ovf: 1'b0
  };

endpackage

FILE: design/etri_ram.sv
// Generic simple dual-port RAM with registered read.
module etri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/etri_dpath.sv
// Datapath: point store, hull stack, cross product pipeline, best area and output register.
module etri_dpath import etri_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [COORD_BITS-1:0]  in_x,
  input  logic signed [COORD_BITS-1:0]  in_y,
  input  etri_cmd_t                     cmd,
  input  logic [$clog2(MAX_POINTS)-1:0] st_waddr,
  input  logic [$clog2(MAX_POINTS)-1:0] st_raddr,
  input  logic [$clog2(MAX_POINTS)-1:0] sk_waddr,
  input  logic [$clog2(MAX_POINTS)-1:0] sk_raddr,
  output etri_sts_t                     sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS+1:0]  out_x,
  output logic signed [COORD_BITS+1:0]  out_y,
  output logic [1:0]                    out_num,
  output logic                          out_last,
  output logic                          out_degen,
  output logic                          out_ovf
);

  localparam int PW = COORD_BITS + 1;      // relative coordinate
  localparam int DW = COORD_BITS + 2;      // difference of two relative points
  localparam int XW = 2 * COORD_BITS + 5;  // cross product
  localparam int OW = COORD_BITS + 3;      // output sum before wrap
  localparam int SW = 2 * PW;

  logic signed [COORD_BITS-1:0] piv_x, piv_y;
  logic signed [PW-1:0] p0_x, p0_y, t_x, t_y, b_x, b_y, top_x, top_y, sec_x, sec_y;
  logic signed [PW-1:0] pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y;
  logic signed [DW-1:0] ux, uy, wx, wy, ux_next, uy_next, wx_next, wy_next;
  logic [PW:0]          man_t, man_b;
  logic signed [2*DW-1:0] prod1, prod2;
  logic signed [XW-1:0] xprod;
  logic [XW-1:0]        area_abs, area_c, best;
  logic                 best_valid;

  logic [SW-1:0]        st_wdata, st_rdata, sk_wdata, sk_rdata;
  logic signed [PW-1:0] st_rx, st_ry, sk_rx, sk_ry, rel_x, rel_y, base_x, base_y;
  logic signed [PW:0]   dif_x, dif_y;
  logic [PW-1:0]        abs_tx, abs_ty, abs_bx, abs_by;
  logic signed [OW-1:0] sum_x, sum_y;

  assign st_rx = st_rdata[PW-1:0];
  assign st_ry = st_rdata[SW-1:PW];
  assign sk_rx = sk_rdata[PW-1:0];
  assign sk_ry = sk_rdata[SW-1:PW];

  // Point relative to pivot, with the pivot swapped into slot zero
  always_comb begin
    base_x = cmd.rel_lo ? p0_x : st_rx;
    base_y = cmd.rel_lo ? p0_y : st_ry;
    dif_x  = (PW+1)'(base_x) - (PW+1)'(piv_x);
    dif_y  = (PW+1)'(base_y) - (PW+1)'(piv_y);
    rel_x  = cmd.rel_zero ? '0 : dif_x[PW-1:0];
    rel_y  = cmd.rel_zero ? '0 : dif_y[PW-1:0];
  end

  // Store write data
  always_comb begin
    case (cmd.st_wsel)
      STW_IN:  st_wdata = {PW'(in_y), PW'(in_x)};
      STW_REL: st_wdata = {rel_y, rel_x};
      STW_B:   st_wdata = {b_y, b_x};
      STW_T:   st_wdata = {t_y, t_x};
      default: st_wdata = '0;
    endcase
  end

  // Stack write data
  always_comb begin
    case (cmd.sk_wsel)
      SKW_ZERO:  sk_wdata = '0;
      SKW_STORE: sk_wdata = st_rdata;
      SKW_B:     sk_wdata = {b_y, b_x};
      default:   sk_wdata = '0;
    endcase
  end

  etri_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_store (
    .clk(clk), .we(cmd.st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  etri_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_stack (
    .clk(clk), .we(cmd.sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
    .raddr(sk_raddr), .rdata(sk_rdata)
  );

  // Point registers
  always_ff @(posedge clk) begin
    if (cmd.piv_ld) begin
      piv_x <= in_x;
      piv_y <= in_y;
    end
    case (cmd.st_cap)
      CAP_P0:  begin p0_x <= st_rx; p0_y <= st_ry; end
      CAP_T:   begin t_x <= st_rx; t_y <= st_ry; end
      CAP_B:   begin b_x <= st_rx; b_y <= st_ry; end
      CAP_TOP: begin top_x <= st_rx; top_y <= st_ry; end
      default: ;
    endcase
    case (cmd.sk_cap)
      CAP_SEC: begin sec_x <= sk_rx; sec_y <= sk_ry; end
      CAP_PA:  begin pa_x <= sk_rx; pa_y <= sk_ry; end
      CAP_PB:  begin pb_x <= sk_rx; pb_y <= sk_ry; end
      CAP_PC:  begin pc_x <= sk_rx; pc_y <= sk_ry; end
      CAP_PD:  begin pd_x <= sk_rx; pd_y <= sk_ry; end
      default: ;
    endcase
    if (cmd.sec_clr) begin
      sec_x <= '0;
      sec_y <= '0;
    end
    if (cmd.push) begin
      sec_x <= top_x;
      sec_y <= top_y;
      top_x <= b_x;
      top_y <= b_y;
    end
    if (cmd.pop) begin
      top_x <= sec_x;
      top_y <= sec_y;
    end
    if (cmd.pc_from_pd) begin
      pc_x <= pd_x;
      pc_y <= pd_y;
    end
  end

  // Cross product operand select
  always_comb begin
    ux_next = ux;
    uy_next = uy;
    wx_next = wx;
    wy_next = wy;
    case (cmd.xsel)
      X_SORT: begin
        ux_next = DW'(t_x);
        uy_next = DW'(t_y);
        wx_next = DW'(b_x);
        wy_next = DW'(b_y);
      end
      X_TURN: begin
        ux_next = DW'(top_x) - DW'(sec_x);
        uy_next = DW'(top_y) - DW'(sec_y);
        wx_next = DW'(b_x) - DW'(top_x);
        wy_next = DW'(b_y) - DW'(top_y);
      end
      X_CLOSE: begin
        ux_next = DW'(top_x) - DW'(sec_x);
        uy_next = DW'(top_y) - DW'(sec_y);
        wx_next = -DW'(top_x);
        wy_next = -DW'(top_y);
      end
      X_AREA_C: begin
        ux_next = DW'(pa_x) - DW'(pb_x);
        uy_next = DW'(pa_y) - DW'(pb_y);
        wx_next = DW'(pa_x) - DW'(pc_x);
        wy_next = DW'(pa_y) - DW'(pc_y);
      end
      X_AREA_D: begin
        ux_next = DW'(pa_x) - DW'(pb_x);
        uy_next = DW'(pa_y) - DW'(pb_y);
        wx_next = DW'(pa_x) - DW'(pd_x);
        wy_next = DW'(pa_y) - DW'(pd_y);
      end
      default: ;
    endcase
  end

  assign abs_tx = t_x[PW-1] ? PW'(-t_x) : PW'(t_x);
  assign abs_ty = t_y[PW-1] ? PW'(-t_y) : PW'(t_y);
  assign abs_bx = b_x[PW-1] ? PW'(-b_x) : PW'(b_x);
  assign abs_by = b_y[PW-1] ? PW'(-b_y) : PW'(b_y);

  // Cross product pipeline: operands, products, difference
  always_ff @(posedge clk) begin
    ux    <= ux_next;
    uy    <= uy_next;
    wx    <= wx_next;
    wy    <= wy_next;
    man_t <= (PW+1)'(abs_tx) + (PW+1)'(abs_ty);
    man_b <= (PW+1)'(abs_bx) + (PW+1)'(abs_by);
    prod1 <= (2*DW)'(ux) * (2*DW)'(wy);
    prod2 <= (2*DW)'(uy) * (2*DW)'(wx);
    xprod <= XW'(prod1) - XW'(prod2);
  end

  assign area_abs = xprod[XW-1] ? XW'(-xprod) : XW'(xprod);

  // Area registers
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (cmd.best_clr) begin
      best_valid <= 1'b0;
    end else if (cmd.best_ld) begin
      best_valid <= 1'b1;
    end
    if (cmd.area_ld) begin
      area_c <= area_abs;
    end
    if (cmd.best_ld) begin
      best <= area_c;
    end
  end

  // Status
  always_comb begin
    sts.in_lt_min  = (in_x < piv_x) || ((in_x == piv_x) && (in_y < piv_y));
    sts.cross_pos  = !xprod[XW-1] && (xprod != '0);
    sts.cross_zero = (xprod == '0);
    sts.man_less   = man_t < man_b;
    sts.c_lt_d     = area_c < area_abs;
    sts.best_upd   = !best_valid || (best < area_c);
    sts.out_free   = !out_valid || out_ready;
  end

  // Output vertex sum: rotation picks A, B and C
  always_comb begin
    case (cmd.out_num)
      2'd0: begin
        sum_x = OW'(pa_x) + OW'(pb_x) - OW'(pc_x);
        sum_y = OW'(pa_y) + OW'(pb_y) - OW'(pc_y);
      end
      2'd1: begin
        sum_x = OW'(pb_x) + OW'(pc_x) - OW'(pa_x);
        sum_y = OW'(pb_y) + OW'(pc_y) - OW'(pa_y);
      end
      default: begin
        sum_x = OW'(pc_x) + OW'(pa_x) - OW'(pb_x);
        sum_y = OW'(pc_y) + OW'(pa_y) - OW'(pb_y);
      end
    endcase
    sum_x = sum_x + OW'(piv_x);
    sum_y = sum_y + OW'(piv_y);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_ld) begin
      out_x     <= cmd.out_degen ? '0 : sum_x[DW-1:0];
      out_y     <= cmd.out_degen ? '0 : sum_y[DW-1:0];
      out_num   <= cmd.out_num;
      out_last  <= cmd.out_last;
      out_degen <= cmd.out_degen;
      out_ovf   <= cmd.out_ovf;
    end
  end

endmodule

FILE: design/etri_ctrl.sv
// Controller: sequences load, pivot shift, insertion sort, Graham scan, sweep and emission.
module etri_ctrl import etri_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_last,
  output logic                          in_ready,
  input  etri_sts_t                     sts,
  output etri_cmd_t                     cmd,
  output logic [$clog2(MAX_POINTS)-1:0] st_waddr,
  output logic [$clog2(MAX_POINTS)-1:0] st_raddr,
  output logic [$clog2(MAX_POINTS)-1:0] sk_waddr,
  output logic [$clog2(MAX_POINTS)-1:0] sk_raddr
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int VW = CW + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

  etri_state_t state, state_next, ret, ret_next;
  logic [CW-1:0] cnt, cnt_next, i, i_next, j, j_next, hc, hc_next;
  logic [IW-1:0] lo, lo_next, c0, c0_next, c1, c1_next, c2, c2_next;
  logic [VW-1:0] v1, v1_next, v2, v2_next, v3, v3_next, k, k_next;
  logic [1:0]    kout, kout_next;
  logic          dropped, dropped_next;
  logic [CW-1:0] jm1, hcm3;
  logic [VW-1:0] v1k, v1p, v3p;
  logic          sorts_first;

  // Index into the circular hull
  function automatic logic [IW-1:0] wrap(input logic [VW-1:0] v, input logic [CW-1:0] m);
    logic [VW-1:0] r;
    r = (v >= VW'(m)) ? v - VW'(m) : v;
    return r[IW-1:0];
  endfunction

  assign jm1    = j - CW'(1);
  assign hcm3   = hc - CW'(3);
  assign v1k    = v1 + k;
  assign v1p    = v1 + VW'(1);
  assign v3p    = v3 + VW'(1);
  assign sorts_first = sts.cross_zero ? sts.man_less : sts.cross_pos;

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      ret     <= S_LOAD;
      cnt     <= '0;
      dropped <= 1'b0;
      hc      <= '0;
    end else begin
      state   <= state_next;
      ret     <= ret_next;
      cnt     <= cnt_next;
      dropped <= dropped_next;
      hc      <= hc_next;
    end
    lo   <= lo_next;
    i    <= i_next;
    j    <= j_next;
    v1   <= v1_next;
    v2   <= v2_next;
    v3   <= v3_next;
    k    <= k_next;
    c0   <= c0_next;
    c1   <= c1_next;
    c2   <= c2_next;
    kout <= kout_next;
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    ret_next     = ret;
    cnt_next     = cnt;
    dropped_next = dropped;
    hc_next      = hc;
    lo_next      = lo;
    i_next       = i;
    j_next       = j;
    v1_next      = v1;
    v2_next      = v2;
    v3_next      = v3;
    k_next       = k;
    c0_next      = c0;
    c1_next      = c1;
    c2_next      = c2;
    kout_next    = kout;
    cmd          = CMD_IDLE;
    in_ready     = 1'b0;
    st_waddr     = '0;
    st_raddr     = '0;
    sk_waddr     = '0;
    sk_raddr     = '0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt < MAXC) begin
            cmd.st_we   = 1'b1;
            cmd.st_wsel = STW_IN;
            st_waddr    = cnt[IW-1:0];
            if (cnt == '0 || sts.in_lt_min) begin
              cmd.piv_ld = 1'b1;
              lo_next    = cnt[IW-1:0];
            end
            cnt_next = cnt + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (in_last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (cnt < CW'(3)) begin
          state_next = S_DEGEN;
        end else begin
          i_next     = '0;
          state_next = S_PR_RD;
        end
      end
      S_PR_RD: begin
        st_raddr   = i[IW-1:0];
        state_next = S_PR_WR;
      end
      S_PR_WR: begin
        cmd.st_cap   = (i == '0) ? CAP_P0 : CAP_NONE;
        cmd.st_we    = 1'b1;
        cmd.st_wsel  = STW_REL;
        cmd.rel_zero = (i == '0);
        cmd.rel_lo   = (i[IW-1:0] == lo);
        st_waddr     = i[IW-1:0];
        if (i + CW'(1) == cnt) begin
          i_next     = CW'(2);
          state_next = S_SO_RD;
        end else begin
          i_next     = i + CW'(1);
          state_next = S_PR_RD;
        end
      end
      // Insertion sort by angle around the pivot
      S_SO_RD: begin
        if (i == cnt) begin
          state_next = S_SC_INIT;
        end else begin
          st_raddr   = i[IW-1:0];
          state_next = S_SO_LD;
        end
      end
      S_SO_LD: begin
        cmd.st_cap = CAP_T;
        j_next     = i;
        state_next = S_SO_CMP;
      end
      S_SO_CMP: begin
        if (j <= CW'(1)) begin
          cmd.st_we   = 1'b1;
          cmd.st_wsel = STW_T;
          st_waddr    = j[IW-1:0];
          i_next      = i + CW'(1);
          state_next  = S_SO_RD;
        end else begin
          st_raddr   = jm1[IW-1:0];
          state_next = S_SO_B;
        end
      end
      S_SO_B: begin
        cmd.st_cap = CAP_B;
        state_next = S_SO_X;
      end
      S_SO_X: begin
        cmd.xsel   = X_SORT;
        ret_next   = S_SO_DEC;
        state_next = S_XW1;
      end
      S_SO_DEC: begin
        cmd.st_we = 1'b1;
        st_waddr  = j[IW-1:0];
        if (sorts_first) begin
          cmd.st_wsel = STW_B;
          j_next      = jm1;
          state_next  = S_SO_CMP;
        end else begin
          cmd.st_wsel = STW_T;
          i_next      = i + CW'(1);
          state_next  = S_SO_RD;
        end
      end
      // Graham scan
      S_SC_INIT: begin
        cmd.sk_we   = 1'b1;
        cmd.sk_wsel = SKW_ZERO;
        sk_waddr    = '0;
        st_raddr    = IW'(1);
        state_next  = S_SC_INIT2;
      end
      S_SC_INIT2: begin
        cmd.st_cap  = CAP_TOP;
        cmd.sec_clr = 1'b1;
        cmd.sk_we   = 1'b1;
        cmd.sk_wsel = SKW_STORE;
        sk_waddr    = IW'(1);
        hc_next     = CW'(2);
        i_next      = CW'(2);
        state_next  = S_SC_RD;
      end
      S_SC_RD: begin
        if (i == cnt) begin
          state_next = S_CL_CHK;
        end else begin
          st_raddr   = i[IW-1:0];
          state_next = S_SC_LD;
        end
      end
      S_SC_LD: begin
        cmd.st_cap = CAP_B;
        state_next = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (hc >= CW'(2)) begin
          cmd.xsel   = X_TURN;
          ret_next   = S_SC_DEC;
          state_next = S_XW1;
        end else begin
          cmd.sk_we   = 1'b1;
          cmd.sk_wsel = SKW_B;
          sk_waddr    = hc[IW-1:0];
          cmd.push    = 1'b1;
          hc_next     = hc + CW'(1);
          i_next      = i + CW'(1);
          state_next  = S_SC_RD;
        end
      end
      S_SC_DEC: begin
        if (sts.cross_pos) begin
          cmd.sk_we   = 1'b1;
          cmd.sk_wsel = SKW_B;
          sk_waddr    = hc[IW-1:0];
          cmd.push    = 1'b1;
          hc_next     = hc + CW'(1);
          i_next      = i + CW'(1);
          state_next  = S_SC_RD;
        end else begin
          cmd.pop = 1'b1;
          hc_next = hc - CW'(1);
          if (hc >= CW'(3)) begin
            sk_raddr   = hcm3[IW-1:0];
            state_next = S_SC_SEC;
          end else begin
            state_next = S_SC_CHK;
          end
        end
      end
      S_SC_SEC: begin
        cmd.sk_cap = CAP_SEC;
        state_next = S_SC_CHK;
      end
      // Closing turn back to the pivot
      S_CL_CHK: begin
        if (hc >= CW'(3)) begin
          cmd.xsel   = X_CLOSE;
          ret_next   = S_CL_DEC;
          state_next = S_XW1;
        end else begin
          state_next = S_SW_INIT;
        end
      end
      S_CL_DEC: begin
        if (sts.cross_pos) begin
          state_next = S_SW_INIT;
        end else begin
          cmd.pop    = 1'b1;
          hc_next    = hc - CW'(1);
          sk_raddr   = hcm3[IW-1:0];
          state_next = S_CL_SEC;
        end
      end
      S_CL_SEC: begin
        cmd.sk_cap = CAP_SEC;
        state_next = S_CL_CHK;
      end
      // Largest triangle sweep
      S_SW_INIT: begin
        if (hc < CW'(3)) begin
          state_next = S_DEGEN;
        end else begin
          v1_next      = '0;
          cmd.best_clr = 1'b1;
          state_next   = S_V1;
        end
      end
      S_V1: begin
        if (v1 == VW'(hc)) begin
          state_next = S_OUT_RD0;
        end else begin
          sk_raddr   = v1[IW-1:0];
          state_next = S_V1A;
        end
      end
      S_V1A: begin
        cmd.sk_cap = CAP_PA;
        v3_next    = v1p;
        sk_raddr   = wrap(v1p, hc);
        state_next = S_V1C;
      end
      S_V1C: begin
        cmd.sk_cap = CAP_PC;
        k_next     = VW'(2);
        state_next = S_K;
      end
      S_K: begin
        if (k == VW'(hc)) begin
          v1_next    = v1p;
          state_next = S_V1;
        end else begin
          v2_next    = v1k;
          sk_raddr   = wrap(v1k, hc);
          state_next = S_KB;
        end
      end
      S_KB: begin
        cmd.sk_cap = CAP_PB;
        state_next = S_AC;
      end
      S_AC: begin
        cmd.xsel   = X_AREA_C;
        ret_next   = S_AC_DEC;
        state_next = S_XW1;
      end
      S_AC_DEC: begin
        cmd.area_ld = 1'b1;
        if (v3p < v2) begin
          sk_raddr   = wrap(v3p, hc);
          state_next = S_AD_LD;
        end else begin
          state_next = S_BEST;
        end
      end
      S_AD_LD: begin
        cmd.sk_cap = CAP_PD;
        state_next = S_AD;
      end
      S_AD: begin
        cmd.xsel   = X_AREA_D;
        ret_next   = S_AD_DEC;
        state_next = S_XW1;
      end
      S_AD_DEC: begin
        if (sts.c_lt_d) begin
          v3_next        = v3p;
          cmd.pc_from_pd = 1'b1;
          state_next     = S_AC;
        end else begin
          state_next = S_BEST;
        end
      end
      S_BEST: begin
        if (sts.best_upd) begin
          cmd.best_ld = 1'b1;
          c0_next     = v1[IW-1:0];
          c1_next     = wrap(v2, hc);
          c2_next     = wrap(v3, hc);
        end
        k_next     = k + VW'(1);
        state_next = S_K;
      end
      // Fetch the three corners
      S_OUT_RD0: begin
        sk_raddr   = c0;
        state_next = S_OUT_RD1;
      end
      S_OUT_RD1: begin
        cmd.sk_cap = CAP_PA;
        sk_raddr   = c1;
        state_next = S_OUT_RD2;
      end
      S_OUT_RD2: begin
        cmd.sk_cap = CAP_PB;
        sk_raddr   = c2;
        state_next = S_OUT_RD3;
      end
      S_OUT_RD3: begin
        cmd.sk_cap = CAP_PC;
        kout_next  = 2'd0;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_num  = kout;
          cmd.out_last = (kout == 2'd2);
          cmd.out_ovf  = dropped;
          if (kout == 2'd2) begin
            cnt_next     = '0;
            dropped_next = 1'b0;
            state_next   = S_LOAD;
          end else begin
            kout_next = kout + 2'd1;
          end
        end
      end
      S_DEGEN: begin
        if (sts.out_free) begin
          cmd.out_ld    = 1'b1;
          cmd.out_degen = 1'b1;
          cmd.out_last  = 1'b1;
          cmd.out_ovf   = dropped;
          cnt_next      = '0;
          dropped_next  = 1'b0;
          state_next    = S_LOAD;
        end
      end
      // Wait states for the cross product pipeline
      S_XW1: state_next = S_XW2;
      S_XW2: state_next = ret;
      default: state_next = S_LOAD;
    endcase
  end

endmodule

FILE: design/enclosing_triangle_from_hull_unit.sv
// Top level: largest hull triangle reported as its enclosing A+B-C triangle.
//
//  channel | dir | transaction
//  s_*     | in  | one point: tdata = point_x, point_y; tlast = last_point
//  m_*     | out | one vertex: tdata = vertex_x, vertex_y; tuser = number, flags
//
// Points load one per cycle. After the last point the block stops taking input
// while it shifts the points to the pivot, sorts them (n^2/4 insertion steps
// average), scans the hull with pushes and pops and sweeps it (O(h^2) steps,
// with the next pointer tried and advanced per apex step); all of these phases
// share the one cross product pipeline.
// Reset is synchronous; the store and stack need no clearing.
// The last vertex may wait in the output register while the next set loads.
module enclosing_triangle_from_hull_unit import etri_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 28
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           s_tvalid,
  output logic                                           s_tready,
  // point_x, point_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]              s_tdata,
  input  logic                                           s_tlast,
  output logic                                           m_tvalid,
  input  logic                                           m_tready,
  // vertex_x, vertex_y
  output logic [((2*COORD_BITS+4+7)/8)*8-1:0]            m_tdata,
  output logic                                           m_tlast,
  // vertex_number[1:0], degenerate, overflow
  output logic [3:0]                                     m_tuser
);

  localparam int IW  = $clog2(MAX_POINTS);
  localparam int ODW = ((2*COORD_BITS+4+7)/8)*8;

  etri_cmd_t cmd;
  etri_sts_t sts;
  logic [IW-1:0] st_waddr, st_raddr, sk_waddr, sk_raddr;
  logic signed [COORD_BITS+1:0] out_x, out_y;
  logic [1:0] out_num;
  logic out_degen, out_ovf;

  etri_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_last(s_tlast), .in_ready(s_tready),
    .sts(sts), .cmd(cmd),
    .st_waddr(st_waddr), .st_raddr(st_raddr), .sk_waddr(sk_waddr), .sk_raddr(sk_raddr)
  );

  etri_dpath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dpath (
    .clk(clk), .rst(rst),
    .in_x(s_tdata[COORD_BITS-1:0]), .in_y(s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .cmd(cmd),
    .st_waddr(st_waddr), .st_raddr(st_raddr), .sk_waddr(sk_waddr), .sk_raddr(sk_raddr),
    .sts(sts),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_x(out_x), .out_y(out_y), .out_num(out_num), .out_last(m_tlast),
    .out_degen(out_degen), .out_ovf(out_ovf)
  );

  // Output packing
  assign m_tdata = ODW'({out_y, out_x});
  assign m_tuser = {out_ovf, out_degen, out_num};

endmodule
